@@ src/nts_pkg.sv @@
// nts_pkg: shared types, register codes and pitch-class helpers for the note-to-chord snapper
// no dependencies; compiled first
`default_nettype none

package nts_pkg;

	localparam int NUM_PC     = 12;
	localparam int VL_SPAN    = 7;
	localparam int VL_CANDS   = 2 * VL_SPAN + 1;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 12;

	typedef logic [6:0]  note_t;
	typedef logic [11:0] pc_mask_t;
	typedef logic [3:0]  pc_t;
	typedef logic [7:0]  score_t;

	localparam note_t    NOTE_MAX       = 7'd127;
	localparam pc_mask_t SCALE_MASK_RST = 12'd2741;
	localparam score_t   SCORE_NONE     = 8'hFF;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SNAP_MODE,
		CFG_TIGHTNESS,
		CFG_VOICE_LEADING,
		CFG_TRANSPOSE,
		CFG_SCALE_ROOT,
		CFG_SCALE_MASK
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SNAP_NEAREST,
		SNAP_DOWN,
		SNAP_UP,
		SNAP_ROOT,
		SNAP_ROOT_FIFTH
	} snap_mode_t;

	typedef enum logic [1:0] {
		TIGHT_STRICT,
		TIGHT_SCALE,
		TIGHT_EXT,
		TIGHT_LOOSE
	} tightness_t;

	// note mod 12 via reciprocal multiply, exact for 0..127
	function automatic pc_t pc_of(input note_t n);
		logic [12:0] prod;
		note_t       q;
		note_t       rem;
		prod = 13'(n) * 13'd43;
		q    = 7'(prod[12:9]);
		rem  = n - q * 7'd12;
		return rem[3:0];
	endfunction

	// (a + b) mod 12, both below 12
	function automatic pc_t pc_add(input pc_t a, input pc_t b);
		logic [4:0] s;
		s = 5'(a) + 5'(b);
		if (s >= 5'd12) begin
			s = s - 5'd12;
		end
		return s[3:0];
	endfunction

	// (a - b) mod 12, both below 12
	function automatic pc_t pc_sub(input pc_t a, input pc_t b);
		pc_t d;
		if (a >= b) begin
			d = a - b;
		end else begin
			d = a + 4'd12 - b;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

@@ src/nts_if.sv @@
// nts_if: valid/ready channels of the note-to-chord snapper (input, result, register write)
// depends on nts_pkg
`default_nettype none

interface nts_in_if;
	import nts_pkg::*;
	logic     valid;
	logic     ready;
	note_t    note_in;
	pc_mask_t chord_mask;
	note_t    last_note;
	logic     has_last;
	modport source (output valid, note_in, chord_mask, last_note, has_last, input ready);
	modport sink (input valid, note_in, chord_mask, last_note, has_last, output ready);
endinterface

interface nts_out_if;
	import nts_pkg::*;
	logic  valid;
	logic  ready;
	note_t note_out;
	modport source (output valid, note_out, input ready);
	modport sink (input valid, note_out, output ready);
endinterface

interface nts_cfg_if;
	import nts_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ src/note_to_chord_snapper.sv @@
// note_to_chord_snapper: snaps incoming notes to chord tones, then transposes and clamps
// depends on nts_pkg and the channel interfaces in nts_if.sv
`default_nettype none

// One note item in, one note item out. Each item is captured in an input register, all of the
// snap, voice-leading and transpose logic runs in one combinational pass, and the note lands in
// a result register, from which dout offers it. A new item can be taken every cycle while the
// output is not stalled. din.ready follows dout.ready through the result register: a stall on
// the output holds the result register, the input register can still take an item if it is
// empty, and then din.ready stays low until the result is taken. Registers are written over
// cfg (always ready) and must only be changed while no item is in flight.
// Register indexes: 0 snap_mode, 1 tightness, 2 voice_leading, 3 transpose (signed), 4
// scale_root, 5 scale_mask; other indexes are accepted and ignored.
module note_to_chord_snapper (
	input  logic        clk,
	input  logic        arst_n,
	nts_cfg_if.sink     cfg,
	nts_in_if.sink      din,
	nts_out_if.source   dout
);
	import nts_pkg::*;

	// configuration registers
	logic [2:0] snap_mode_q;
	tightness_t tightness_q;
	logic       voice_leading_q;
	logic [7:0] transpose_q;
	pc_t        scale_root_q;
	pc_mask_t   scale_mask_q;

	// input register
	logic     valid_s1;
	note_t    note_s1;
	pc_mask_t mask_s1;
	note_t    last_s1;
	logic     has_last_s1;

	// result register
	logic  valid_s2;
	note_t note_s2;

	logic advance;

	// combinational datapath
	pc_t      pc;
	pc_t      scale_root_m;
	logic     chord_tone;
	logic     go;
	pc_t      root_pc;
	pc_t      fifth_pc;
	pc_mask_t root_mask;
	pc_mask_t sel_mask;
	logic     dn_found, up_found;
	pc_t      dn_dist, up_dist;
	note_t    dn_note, up_note, nearest_note;
	note_t    base_note;
	note_t    cand_note [VL_CANDS];
	logic     cand_ok [VL_CANDS];
	score_t   cand_score [VL_CANDS];
	logic [VL_CANDS-1:0] win;
	note_t    vl_note;
	note_t    snap_note;
	note_t    held_note;
	logic signed [9:0] sum;
	note_t    result;

	// ---------------------------------------------------------------- register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_mode_q     <= SNAP_NEAREST;
			tightness_q     <= TIGHT_STRICT;
			voice_leading_q <= 1'b0;
			transpose_q     <= '0;
			scale_root_q    <= '0;
			scale_mask_q    <= SCALE_MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_SNAP_MODE:     snap_mode_q     <= cfg.wdata[2:0];
				CFG_TIGHTNESS:     tightness_q     <= tightness_t'(cfg.wdata[1:0]);
				CFG_VOICE_LEADING: voice_leading_q <= cfg.wdata[0];
				CFG_TRANSPOSE:     transpose_q     <= cfg.wdata[7:0];
				CFG_SCALE_ROOT:    scale_root_q    <= cfg.wdata[3:0];
				CFG_SCALE_MASK:    scale_mask_q    <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	// result register moves when empty or being taken; input register refills behind it
	assign advance   = !valid_s2 || dout.ready;
	assign din.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			note_s1     <= din.note_in;
			mask_s1     <= din.chord_mask;
			last_s1     <= din.last_note;
			has_last_s1 <= din.has_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			note_s2 <= result;
		end
	end

	assign dout.valid    = valid_s2;
	assign dout.note_out = note_s2;

	// ---------------------------------------------------------------- snap decision
	assign pc           = pc_of(note_s1);
	assign chord_tone   = mask_s1[pc];
	// scale root codes 12..15 wrap
	assign scale_root_m = (scale_root_q >= 4'd12) ? scale_root_q - 4'd12 : scale_root_q;

	always_comb begin
		case (tightness_q)
			TIGHT_STRICT: go = 1'b1;
			TIGHT_SCALE:  go = !scale_mask_q[pc_sub(pc, scale_root_m)];
			// avoid note: a half step above a chord tone
			TIGHT_EXT:    go = !chord_tone && mask_s1[pc_sub(pc, 4'd1)];
			TIGHT_LOOSE:  go = !chord_tone && (mask_s1[pc_sub(pc, 4'd1)] ||
			                                   mask_s1[pc_add(pc, 4'd1)]);
			default:      go = 1'b1;
		endcase
	end

	// ---------------------------------------------------------------- root and target mask
	always_comb begin
		root_pc = '0;
		for (int i = NUM_PC - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				root_pc = 4'(i);
			end
		end
	end

	assign fifth_pc = pc_add(root_pc, 4'd7);

	always_comb begin
		root_mask          = '0;
		root_mask[root_pc] = 1'b1;
	end

	always_comb begin
		case (snap_mode_q)
			SNAP_ROOT:       sel_mask = root_mask;
			SNAP_ROOT_FIFTH: sel_mask = root_mask | (pc_mask_t'(1) << fifth_pc);
			default:         sel_mask = mask_s1;
		endcase
	end

	// ---------------------------------------------------------------- nearest tone below / above
	// scan offsets from far to near so the closest hit is the one kept
	always_comb begin
		dn_found = 1'b0;
		up_found = 1'b0;
		dn_dist  = '0;
		up_dist  = '0;
		for (int k = NUM_PC - 1; k >= 0; k--) begin
			if (sel_mask[pc_sub(pc, 4'(k))] && (note_s1 >= 7'(k))) begin
				dn_found = 1'b1;
				dn_dist  = 4'(k);
			end
			if (sel_mask[pc_add(pc, 4'(k))] && ((8'(note_s1) + 8'(k)) <= 8'(NOTE_MAX))) begin
				up_found = 1'b1;
				up_dist  = 4'(k);
			end
		end
	end

	assign dn_note = note_s1 - 7'(dn_dist);
	assign up_note = note_s1 + 7'(up_dist);
	// ties go to the lower note
	assign nearest_note = (dn_found && (!up_found || dn_dist <= up_dist)) ? dn_note : up_note;

	always_comb begin
		case (snap_mode_q) inside
			SNAP_NEAREST, SNAP_ROOT, SNAP_ROOT_FIFTH: base_note = nearest_note;
			SNAP_DOWN: base_note = dn_found ? dn_note : note_s1;
			SNAP_UP:   base_note = up_found ? up_note : note_s1;
			default:   base_note = note_s1;
		endcase
	end

	// ---------------------------------------------------------------- voice leading
	// candidates note-7 .. note+7, score 2*|offset| + |candidate - last|
	always_comb begin
		logic signed [8:0] t;
		pc_t               cpc;
		note_t             dl;
		for (int o = 0; o < VL_CANDS; o++) begin
			t   = $signed({2'b00, note_s1}) + 9'(o - VL_SPAN);
			cpc = (o < VL_SPAN) ? pc_sub(pc, 4'(VL_SPAN - o)) : pc_add(pc, 4'(o - VL_SPAN));
			cand_note[o] = t[6:0];
			cand_ok[o]   = (t >= 0) && (t <= $signed({2'b00, NOTE_MAX})) && mask_s1[cpc];
			dl = (t[6:0] >= last_s1) ? t[6:0] - last_s1 : last_s1 - t[6:0];
			cand_score[o] = cand_ok[o] ?
				(8'((o < VL_SPAN) ? (VL_SPAN - o) : (o - VL_SPAN)) * 8'd2) + 8'(dl) :
				SCORE_NONE;
		end
	end

	// a candidate wins when strictly below every lower one and not above any higher one
	always_comb begin
		for (int i = 0; i < VL_CANDS; i++) begin
			win[i] = cand_ok[i];
			for (int j = 0; j < VL_CANDS; j++) begin
				if (j < i && !(cand_score[i] < cand_score[j])) begin
					win[i] = 1'b0;
				end
				if (j > i && !(cand_score[i] <= cand_score[j])) begin
					win[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		vl_note = '0;
		for (int i = 0; i < VL_CANDS; i++) begin
			vl_note = vl_note | (win[i] ? cand_note[i] : '0);
		end
	end

	assign snap_note = (voice_leading_q && has_last_s1 && (|win)) ? vl_note : base_note;
	assign held_note = ((mask_s1 != '0) && go) ? snap_note : note_s1;

	// ---------------------------------------------------------------- transpose and clamp
	assign sum = $signed({3'b000, held_note}) + $signed({{2{transpose_q[7]}}, transpose_q});

	always_comb begin
		if (sum < 0) begin
			result = '0;
		end else if (sum > $signed({3'b000, NOTE_MAX})) begin
			result = NOTE_MAX;
		end else begin
			result = sum[6:0];
		end
	end

`ifndef NO_ASSERTIONS
	// an item in the input register moves to the result register when the output frees
	a_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> valid_s2)
		else $error("item lost between input and result register");

	// a stalled input register keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(note_s1) && $stable(mask_s1)))
		else $error("stalled item overwritten");

	// no chord and no transpose passes the note straight through
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && mask_s1 == '0 && transpose_q == '0) |=>
		(dout.note_out == $past(note_s1)))
		else $error("empty chord did not pass note through");

	// nearest snap always lands on a chord tone
	a_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mask_s1 != '0 && snap_mode_q == SNAP_NEAREST) |->
		mask_s1[pc_of(base_note)])
		else $error("nearest snap left the chord");

	// at most one voice-leading winner
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(win))
		else $error("several voice-leading winners");
`endif

endmodule

`default_nettype wire
